>>> rtl/double_tap_calibration_marker_unit_macros.svh
// Assertion macros used by the port-level checker of the calibration marker.
`ifndef DOUBLE_TAP_CALIBRATION_MARKER_UNIT_MACROS_SVH
`define DOUBLE_TAP_CALIBRATION_MARKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define DTCM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtcm assertion failed");

// Next-cycle implication, disabled while reset is active.
`define DTCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtcm assertion failed");

`endif

>>> rtl/dtcm_pkg.sv
// Types and constants shared by the calibration marker and its checker.
package dtcm_pkg;

    localparam int COORD_W = 12;
    localparam int CFG_W   = 25;
    localparam int TIME_W  = 32;
    localparam int TMO_W   = 16;

    // The point index and point count fields of a result are sized for this count.
    localparam int POINT_COUNT = 4;

    localparam logic [CFG_W-1:0] MIN_DIST_RST      = 25'd10000;
    localparam logic [CFG_W-1:0] TRACK_RADIUS_RST  = 25'd9;
    localparam logic [TMO_W-1:0] TAP_TIMEOUT_RST   = 16'd500;

    typedef enum logic [1:0] {
        ACT_SPOT    = 2'd0,
        ACT_EOF     = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_MIN_DIST     = 2'd0,
        REG_TRACK_RADIUS = 2'd1,
        REG_TAP_TIMEOUT  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        TAP_READY   = 3'd0,
        TAP_DOWN1   = 3'd1,
        TAP_UP1     = 3'd2,
        TAP_DOWN2   = 3'd3,
        TAP_UP2     = 3'd4,
        TAP_TIMEOUT = 3'd5
    } tap_phase_t;

    typedef enum logic [1:0] {
        RUN_READY   = 2'd0,
        RUN_RUNNING = 2'd1,
        RUN_END     = 2'd2
    } run_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLAIM,
        ST_MATCH,
        ST_NEW,
        ST_ABSENT,
        ST_ACCEPT,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] spot_x;
        logic [COORD_W-1:0] spot_y;
        logic [TIME_W-1:0]  now_ms;
    } cmd_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [1:0]         point_index;
        logic [2:0]         points_done;
        logic               complete;
        logic               last;
    } res_t;

endpackage

>>> rtl/double_tap_calibration_marker_unit.sv
// Top level of the double-tap calibration marker: spot buffer, tracks and sequencer.
// A spot, restart or ignored item leaves busy low; an end-of-frame item runs its
// distance tests one after another on the single shared squarer.
// Throughput: one item at a time; start is taken only while busy is low.
// Reset (rst_n, asynchronous, active low) clears points, tracks, the spot buffer and
// the run phase, and loads the register defaults; results cannot be stalled.
module double_tap_calibration_marker_unit #(
    parameter int MAX_SPOTS   = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  dtcm_pkg::cmd_t             cmd,
    output logic                       busy,
    output logic                       result_strobe,
    output dtcm_pkg::res_t             result,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [dtcm_pkg::CFG_W-1:0] cfg_data
);
    import dtcm_pkg::*;

    // Index widths: SW/PW address an entry, CW/PCW also hold the full count.
    localparam int SW    = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
    localparam int CW    = $clog2(MAX_SPOTS + 1);
    localparam int PW    = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
    localparam int PCW   = $clog2(POINT_COUNT + 1);
    localparam int SQ_W  = 2 * COORD_W;
    localparam int DS_W  = SQ_W + 1;
    localparam int CMP_W = (DS_W > CFG_W) ? DS_W : CFG_W;
    localparam logic [1:0] DPH_LAST = 2'd2;

    // Configuration registers.
    logic [CFG_W-1:0] min_dist_reg;
    logic [CFG_W-1:0] radius_reg;
    logic [TMO_W-1:0] timeout_reg;

    // Control state.
    state_t     state_reg, state_next;
    run_phase_t run_reg, run_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [CW-1:0]  w_reg, w_next;
    logic [PCW-1:0] k_reg, k_next;
    logic [1:0]     dph_reg, dph_next;
    logic [CW-1:0]  st_reg, st_next;
    logic [CW-1:0]  tt_reg, tt_next;
    logic [PCW-1:0] pt_reg, pt_next;
    logic           proc_reg, proc_next;
    logic           res_valid_reg, res_valid_next;
    res_t           res_reg, res_next;
    logic [TIME_W-1:0] now_reg, now_next;

    tap_phase_t phase_reg [MAX_SPOTS];
    tap_phase_t phase_next [MAX_SPOTS];
    logic [MAX_SPOTS-1:0] seen_reg, seen_next;
    logic [MAX_SPOTS-1:0] claimed_reg, claimed_next;

    // Storage without reset; every entry is written before it is read.
    logic [COORD_W-1:0] spot_x_mem [MAX_SPOTS];
    logic [COORD_W-1:0] spot_y_mem [MAX_SPOTS];
    logic [COORD_W-1:0] trk_x_mem [MAX_SPOTS];
    logic [COORD_W-1:0] trk_y_mem [MAX_SPOTS];
    logic [TIME_W-1:0]  stamp_mem [MAX_SPOTS];
    logic [COORD_W-1:0] pt_x_mem [POINT_COUNT];
    logic [COORD_W-1:0] pt_y_mem [POINT_COUNT];

    // Write controls.
    logic               spot_we;
    logic               pt_we;
    logic               trk_pos_we;
    logic               trk_stamp_we;
    logic [SW-1:0]      trk_widx;
    logic [COORD_W-1:0] trk_wx;
    logic [COORD_W-1:0] trk_wy;
    logic [TIME_W-1:0]  trk_wstamp;

    // Read ports, one address each.
    logic [SW-1:0]      iidx, jidx, widx, tidx;
    logic [PW-1:0]      kidx;
    logic [COORD_W-1:0] spot_rx, spot_ry, trk_rx, trk_ry, pt_rx, pt_ry;
    logic [TIME_W-1:0]  stamp_rd;
    tap_phase_t         phase_rd;

    // Shared distance unit.
    logic [COORD_W-1:0] a_x, a_y, b_x, b_y, dx, dy, dsel;
    logic [CFG_W-1:0]   thr;
    logic [SQ_W-1:0]    sq, sq_reg;
    logic [DS_W-1:0]    sum_reg;
    logic               dist_lt;

    // Tap machine for the track at index j.
    logic [TIME_W-1:0]  elapsed;
    logic               timed_out;
    logic               present;
    tap_phase_t         tap_ph_new;
    logic               tap_stamp_we;
    logic               tap_pos_we;

    // Loop conditions.
    logic           i_end, j_end, k_end, dist_rdy;
    logic [PCW-1:0] pt_inc;
    logic           finished;

    assign iidx = i_reg[SW-1:0];
    assign jidx = j_reg[SW-1:0];
    assign widx = w_reg[SW-1:0];
    assign tidx = tt_reg[SW-1:0];
    assign kidx = k_reg[PW-1:0];

    assign spot_rx  = spot_x_mem[iidx];
    assign spot_ry  = spot_y_mem[iidx];
    assign trk_rx   = trk_x_mem[jidx];
    assign trk_ry   = trk_y_mem[jidx];
    assign stamp_rd = stamp_mem[jidx];
    assign phase_rd = phase_reg[jidx];
    assign pt_rx    = pt_x_mem[kidx];
    assign pt_ry    = pt_y_mem[kidx];

    assign i_end    = (i_reg == st_reg);
    assign j_end    = (j_reg == tt_reg);
    assign k_end    = (k_reg == pt_reg);
    assign dist_rdy = (dph_reg == DPH_LAST);
    assign pt_inc   = pt_reg + PCW'(1);
    assign finished = (run_reg != RUN_READY) && proc_reg && (pt_reg >= PCW'(POINT_COUNT));

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = res_valid_reg;
    assign result        = res_reg;

    // The distance unit compares a spot or track against a point or track. The one
    // squarer produces dx^2 into sq_reg and then dy^2, whose sum goes to sum_reg; the
    // last phase compares the sum against the threshold of the current pass.
    always_comb
    begin
        case (state_reg)
            ST_CLAIM:
            begin
                a_x = spot_rx;  a_y = spot_ry;
                b_x = pt_rx;    b_y = pt_ry;
                thr = min_dist_reg;
            end
            ST_MATCH:
            begin
                a_x = spot_rx;  a_y = spot_ry;
                b_x = trk_rx;   b_y = trk_ry;
                thr = radius_reg;
            end
            default:
            begin
                a_x = trk_rx;   a_y = trk_ry;
                b_x = pt_rx;    b_y = pt_ry;
                thr = min_dist_reg;
            end
        endcase
    end

    assign dx      = (a_x > b_x) ? (a_x - b_x) : (b_x - a_x);
    assign dy      = (a_y > b_y) ? (a_y - b_y) : (b_y - a_y);
    assign dsel    = (dph_reg == 2'd0) ? dx : dy;
    assign sq      = dsel * dsel;
    assign dist_lt = (CMP_W'(sum_reg) < CMP_W'(thr));

    always_ff @(posedge clk)
    begin
        if (dph_reg == 2'd0)
        begin
            sq_reg <= sq;
        end
        if (dph_reg == 2'd1)
        begin
            sum_reg <= {1'b0, sq_reg} + {1'b0, sq};
        end
    end

    // One tap step: a spot present in the matching pass, absent in the absent pass.
    // The elapsed time wraps modulo 2^32.
    assign present   = (state_reg == ST_MATCH);
    assign elapsed   = now_reg - stamp_rd;
    assign timed_out = (elapsed > TIME_W'(timeout_reg));

    always_comb
    begin
        tap_ph_new   = phase_rd;
        tap_stamp_we = 1'b0;
        tap_pos_we   = 1'b0;
        case (phase_rd)
            TAP_READY:
            begin
                if (present)
                begin
                    tap_ph_new   = TAP_DOWN1;
                    tap_stamp_we = 1'b1;
                    tap_pos_we   = 1'b1;
                end
            end
            TAP_DOWN1:
            begin
                if (!present)
                begin
                    tap_ph_new   = TAP_UP1;
                    tap_stamp_we = 1'b1;
                end
                else if (timed_out)
                begin
                    tap_ph_new = TAP_TIMEOUT;
                end
            end
            TAP_UP1:
            begin
                if (present)
                begin
                    tap_ph_new   = TAP_DOWN2;
                    tap_stamp_we = 1'b1;
                end
                else if (timed_out)
                begin
                    tap_ph_new = TAP_TIMEOUT;
                end
            end
            TAP_DOWN2:
            begin
                if (!present)
                begin
                    tap_ph_new = TAP_UP2;
                end
            end
            default:
            begin
                tap_ph_new = phase_rd;
            end
        endcase
    end

    // Sequencer next state. An end-of-frame item with neither spots nor tracks goes
    // straight to the summary, unless the run has ended.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (cmd.action == ACT_EOF) && (run_reg != RUN_END))
                begin
                    if ((st_reg != '0) || (tt_reg != '0))
                    begin
                        state_next = ST_CLAIM;
                    end
                    else
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_CLAIM:  if (i_end) state_next = ST_MATCH;
            ST_MATCH:  if (i_end) state_next = ST_NEW;
            ST_NEW:    if (i_end) state_next = ST_ABSENT;
            ST_ABSENT: if (j_end) state_next = ST_ACCEPT;
            ST_ACCEPT: if (j_end) state_next = ST_SUM;
            ST_SUM:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer datapath and result outputs.
    always_comb
    begin
        run_next       = run_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        k_next         = k_reg;
        dph_next       = dph_reg;
        st_next        = st_reg;
        tt_next        = tt_reg;
        pt_next        = pt_reg;
        proc_next      = proc_reg;
        now_next       = now_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        phase_next     = phase_reg;
        seen_next      = seen_reg;
        claimed_next   = claimed_reg;
        spot_we        = 1'b0;
        pt_we          = 1'b0;
        trk_pos_we     = 1'b0;
        trk_stamp_we   = 1'b0;
        trk_widx       = jidx;
        trk_wx         = spot_rx;
        trk_wy         = spot_ry;
        trk_wstamp     = now_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.action)
                        ACT_RESTART:
                        begin
                            run_next     = RUN_READY;
                            pt_next      = '0;
                            tt_next      = '0;
                            st_next      = '0;
                            seen_next    = '0;
                            claimed_next = '0;
                            for (int n = 0; n < MAX_SPOTS; n++)
                            begin
                                phase_next[n] = TAP_READY;
                            end
                        end
                        ACT_SPOT:
                        begin
                            if ((run_reg != RUN_END) && (st_reg < CW'(MAX_SPOTS)))
                            begin
                                spot_we = 1'b1;
                                st_next = st_reg + CW'(1);
                            end
                        end
                        ACT_EOF:
                        begin
                            if (run_reg == RUN_END)
                            begin
                                st_next = '0;
                            end
                            else
                            begin
                                now_next  = cmd.now_ms;
                                proc_next = (st_reg != '0) || (tt_reg != '0);
                                seen_next = '0;
                                i_next    = '0;
                                k_next    = '0;
                                dph_next  = '0;
                            end
                        end
                        default:
                        begin
                            run_next = run_reg;
                        end
                    endcase
                end
            end

            // Mark spots lying near an accepted point.
            ST_CLAIM:
            begin
                if (i_end)
                begin
                    i_next   = '0;
                    j_next   = '0;
                    dph_next = '0;
                end
                else if (k_end)
                begin
                    claimed_next[iidx] = 1'b0;
                    i_next = i_reg + CW'(1);
                    k_next = '0;
                end
                else if (!dist_rdy)
                begin
                    dph_next = dph_reg + 2'd1;
                end
                else
                begin
                    dph_next = '0;
                    if (dist_lt)
                    begin
                        claimed_next[iidx] = 1'b1;
                        i_next = i_reg + CW'(1);
                        k_next = '0;
                    end
                    else
                    begin
                        k_next = k_reg + PCW'(1);
                    end
                end
            end

            // Each free spot continues the first unseen track within the radius.
            ST_MATCH:
            begin
                if (i_end)
                begin
                    i_next = '0;
                end
                else if (claimed_reg[iidx] || j_end)
                begin
                    i_next = i_reg + CW'(1);
                    j_next = '0;
                end
                else if (seen_reg[jidx])
                begin
                    j_next = j_reg + CW'(1);
                end
                else if (!dist_rdy)
                begin
                    dph_next = dph_reg + 2'd1;
                end
                else
                begin
                    dph_next = '0;
                    if (dist_lt)
                    begin
                        phase_next[jidx]   = tap_ph_new;
                        seen_next[jidx]    = 1'b1;
                        trk_pos_we         = tap_pos_we;
                        trk_stamp_we       = tap_stamp_we;
                        claimed_next[iidx] = 1'b1;
                        i_next = i_reg + CW'(1);
                        j_next = '0;
                    end
                    else
                    begin
                        j_next = j_reg + CW'(1);
                    end
                end
            end

            // Remaining spots open new tracks while room remains.
            ST_NEW:
            begin
                trk_widx = tidx;
                if (i_end)
                begin
                    j_next = '0;
                end
                else if (claimed_reg[iidx] || (tt_reg >= CW'(MAX_SPOTS)))
                begin
                    i_next = i_reg + CW'(1);
                end
                else
                begin
                    trk_pos_we       = 1'b1;
                    trk_stamp_we     = 1'b1;
                    phase_next[tidx] = TAP_DOWN1;
                    seen_next[tidx]  = 1'b1;
                    tt_next = tt_reg + CW'(1);
                    i_next  = i_reg + CW'(1);
                end
            end

            // Tracks without a spot this frame take an absent step.
            ST_ABSENT:
            begin
                if (j_end)
                begin
                    j_next   = '0;
                    w_next   = '0;
                    k_next   = '0;
                    dph_next = '0;
                end
                else
                begin
                    if (!seen_reg[jidx])
                    begin
                        phase_next[jidx] = tap_ph_new;
                        seen_next[jidx]  = 1'b1;
                        trk_stamp_we     = tap_stamp_we;
                    end
                    j_next = j_reg + CW'(1);
                end
            end

            // Finished double taps far from every point become points while fewer than
            // POINT_COUNT exist; finished and timed-out tracks are removed, the rest packed down.
            ST_ACCEPT:
            begin
                trk_widx   = widx;
                trk_wx     = trk_rx;
                trk_wy     = trk_ry;
                trk_wstamp = stamp_rd;
                if (j_end)
                begin
                    for (int n = 0; n < MAX_SPOTS; n++)
                    begin
                        if (CW'(n) >= w_reg)
                        begin
                            phase_next[n] = TAP_READY;
                            seen_next[n]  = 1'b0;
                        end
                    end
                    tt_next = w_reg;
                end
                else if (phase_rd == TAP_UP2)
                begin
                    if (pt_reg >= PCW'(POINT_COUNT))
                    begin
                        j_next = j_reg + CW'(1);
                        k_next = '0;
                    end
                    else if (k_end)
                    begin
                        pt_we                = 1'b1;
                        pt_next              = pt_inc;
                        res_valid_next       = 1'b1;
                        res_next.kind        = 1'b0;
                        res_next.point_x     = trk_rx;
                        res_next.point_y     = trk_ry;
                        res_next.point_index = 2'(pt_reg);
                        res_next.points_done = 3'(pt_inc);
                        res_next.complete    = (pt_inc == PCW'(POINT_COUNT));
                        res_next.last        = 1'b0;
                        j_next = j_reg + CW'(1);
                        k_next = '0;
                    end
                    else if (!dist_rdy)
                    begin
                        dph_next = dph_reg + 2'd1;
                    end
                    else
                    begin
                        dph_next = '0;
                        if (dist_lt)
                        begin
                            j_next = j_reg + CW'(1);
                            k_next = '0;
                        end
                        else
                        begin
                            k_next = k_reg + PCW'(1);
                        end
                    end
                end
                else if (phase_rd == TAP_TIMEOUT)
                begin
                    j_next = j_reg + CW'(1);
                end
                else
                begin
                    trk_pos_we       = 1'b1;
                    trk_stamp_we     = 1'b1;
                    phase_next[widx] = phase_rd;
                    seen_next[widx]  = seen_reg[jidx];
                    w_next = w_reg + CW'(1);
                    j_next = j_reg + CW'(1);
                end
            end

            // Frame summary and run-phase update.
            ST_SUM:
            begin
                if (run_reg == RUN_READY)
                begin
                    run_next = RUN_RUNNING;
                end
                else if (finished)
                begin
                    run_next = RUN_END;
                end
                res_valid_next       = 1'b1;
                res_next.kind        = 1'b1;
                res_next.point_x     = '0;
                res_next.point_y     = '0;
                res_next.point_index = '0;
                res_next.points_done = 3'(pt_reg);
                res_next.complete    = finished;
                res_next.last        = finished;
                st_next = '0;
            end

            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            run_reg       <= RUN_READY;
            i_reg         <= '0;
            j_reg         <= '0;
            w_reg         <= '0;
            k_reg         <= '0;
            dph_reg       <= '0;
            st_reg        <= '0;
            tt_reg        <= '0;
            pt_reg        <= '0;
            proc_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            seen_reg      <= '0;
            claimed_reg   <= '0;
            for (int n = 0; n < MAX_SPOTS; n++)
            begin
                phase_reg[n] <= TAP_READY;
            end
            min_dist_reg  <= MIN_DIST_RST;
            radius_reg    <= TRACK_RADIUS_RST;
            timeout_reg   <= TAP_TIMEOUT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            run_reg       <= run_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            w_reg         <= w_next;
            k_reg         <= k_next;
            dph_reg       <= dph_next;
            st_reg        <= st_next;
            tt_reg        <= tt_next;
            pt_reg        <= pt_next;
            proc_reg      <= proc_next;
            res_valid_reg <= res_valid_next;
            seen_reg      <= seen_next;
            claimed_reg   <= claimed_next;
            phase_reg     <= phase_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_DIST:     min_dist_reg <= cfg_data;
                    REG_TRACK_RADIUS: radius_reg   <= cfg_data;
                    REG_TAP_TIMEOUT:  timeout_reg  <= cfg_data[TMO_W-1:0];
                    default:          timeout_reg  <= timeout_reg;
                endcase
            end
        end
    end

    // Payload registers and stores.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        now_reg <= now_next;
        if (spot_we)
        begin
            spot_x_mem[st_reg[SW-1:0]] <= cmd.spot_x;
            spot_y_mem[st_reg[SW-1:0]] <= cmd.spot_y;
        end
        if (pt_we)
        begin
            pt_x_mem[pt_reg[PW-1:0]] <= trk_rx;
            pt_y_mem[pt_reg[PW-1:0]] <= trk_ry;
        end
        if (trk_pos_we)
        begin
            trk_x_mem[trk_widx] <= trk_wx;
            trk_y_mem[trk_widx] <= trk_wy;
        end
        if (trk_stamp_we)
        begin
            stamp_mem[trk_widx] <= trk_wstamp;
        end
    end

endmodule

>>> rtl/dtcm_checker.sv
// Port-level checker for the calibration marker, bound to its top level.
`include "double_tap_calibration_marker_unit_macros.svh"

module dtcm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           busy,
    input logic           result_strobe,
    input dtcm_pkg::res_t result
);
    import dtcm_pkg::*;

    // Point results appear while the frame is still being worked on.
    `DTCM_ASSERT_IMPL(a_point_busy_now, clk, rst_n, result_strobe && !result.kind, busy)
    // Only a frame summary may end the run.
    `DTCM_ASSERT_IMPL(a_last_summary, clk, rst_n, result_strobe && result.last, result.kind)
    // The summary is the final result of a frame; it shows once the block is free.
    `DTCM_ASSERT_IMPL(a_sum_idle, clk, rst_n, result_strobe && result.kind, !busy)
    // A point result is always followed by more work on the same frame.
    `DTCM_ASSERT_NEXT(a_point_busy, clk, rst_n, result_strobe && !result.kind, busy)

endmodule

bind double_tap_calibration_marker_unit dtcm_checker u_dtcm_checker (.*);

>>> dv/double_tap_calibration_marker_unit_checker.sv
// Checker for the calibration marker: predicts every result item and compares it.
`timescale 1ns / 100ps

module double_tap_calibration_marker_unit_checker #(
    parameter int MAX_SPOTS   = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  dtcm_pkg::cmd_t             cmd,
    input  logic                       result_strobe,
    input  dtcm_pkg::res_t             result,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [dtcm_pkg::CFG_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         outstanding,
    output int                         results_seen,
    output int                         points_seen
);
    import dtcm_pkg::*;

    logic [CFG_W-1:0]   near_limit;
    logic [CFG_W-1:0]   radius_limit;
    logic [TMO_W-1:0]   tap_limit;

    run_phase_t         run_ph;
    logic [COORD_W-1:0] mark_x [POINT_COUNT];
    logic [COORD_W-1:0] mark_y [POINT_COUNT];
    int                 mark_cnt;

    logic [COORD_W-1:0] trk_x [MAX_SPOTS];
    logic [COORD_W-1:0] trk_y [MAX_SPOTS];
    tap_phase_t         trk_ph [MAX_SPOTS];
    logic [TIME_W-1:0]  trk_t [MAX_SPOTS];
    bit                 trk_hit [MAX_SPOTS];
    int                 trk_cnt;

    logic [COORD_W-1:0] spot_x_buf [MAX_SPOTS];
    logic [COORD_W-1:0] spot_y_buf [MAX_SPOTS];
    bit                 spot_taken [MAX_SPOTS];
    int                 spot_cnt;

    res_t               pending_results [$];

    assign outstanding = pending_results.size();

    function automatic longint sq_dist(int ax, int ay, int bx, int by);
        longint dx;
        longint dy;
        dx = ax - bx;
        dy = ay - by;
        return dx * dx + dy * dy;
    endfunction

    function automatic bit near_marker(int x, int y);
        for (int j = 0; j < mark_cnt; j++)
            if (sq_dist(x, y, mark_x[j], mark_y[j]) < longint'(near_limit))
                return 1'b1;
        return 1'b0;
    endfunction

    // Clears the run: points, tracks and buffered spots; registers are kept.
    task automatic clear_run();
        run_ph   = RUN_READY;
        mark_cnt = 0;
        trk_cnt  = 0;
        spot_cnt = 0;
        for (int j = 0; j < MAX_SPOTS; j++)
        begin
            trk_ph[j]     = TAP_READY;
            trk_hit[j]    = 1'b0;
            spot_taken[j] = 1'b0;
        end
    endtask

    task automatic tap_advance(int t, bit present, logic [COORD_W-1:0] x,
                               logic [COORD_W-1:0] y, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        elapsed = now - trk_t[t];
        case (trk_ph[t])
            TAP_READY:
                if (present)
                begin
                    trk_x[t]  = x;
                    trk_y[t]  = y;
                    trk_ph[t] = TAP_DOWN1;
                    trk_t[t]  = now;
                end
            TAP_DOWN1:
                if (!present)
                begin
                    trk_t[t]  = now;
                    trk_ph[t] = TAP_UP1;
                end
                else if (elapsed > TIME_W'(tap_limit))
                    trk_ph[t] = TAP_TIMEOUT;
            TAP_UP1:
                if (present)
                begin
                    trk_t[t]  = now;
                    trk_ph[t] = TAP_DOWN2;
                end
                else if (elapsed > TIME_W'(tap_limit))
                    trk_ph[t] = TAP_TIMEOUT;
            TAP_DOWN2:
                if (!present)
                    trk_ph[t] = TAP_UP2;
            default: ;
        endcase
        trk_hit[t] = 1'b1;
    endtask

    task automatic push_result(bit kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                               int idx, int done, bit comp, bit fin);
        res_t r;
        r.kind        = kind;
        r.point_x     = x;
        r.point_y     = y;
        r.point_index = 2'(idx);
        r.points_done = 3'(done);
        r.complete    = comp;
        r.last        = fin;
        pending_results.push_back(r);
    endtask

    task automatic run_frame(logic [TIME_W-1:0] now);
        int w;
        for (int j = 0; j < MAX_SPOTS; j++)
            trk_hit[j] = 1'b0;
        for (int i = 0; i < spot_cnt; i++)
            spot_taken[i] = near_marker(spot_x_buf[i], spot_y_buf[i]);

        // Each free spot continues the first unseen track within the radius.
        for (int i = 0; i < spot_cnt; i++)
        begin
            if (spot_taken[i])
                continue;
            for (int j = 0; j < trk_cnt; j++)
            begin
                if (trk_hit[j])
                    continue;
                if (sq_dist(spot_x_buf[i], spot_y_buf[i], trk_x[j], trk_y[j])
                        < longint'(radius_limit))
                begin
                    tap_advance(j, 1'b1, spot_x_buf[i], spot_y_buf[i], now);
                    spot_taken[i] = 1'b1;
                    break;
                end
            end
        end

        for (int i = 0; i < spot_cnt; i++)
        begin
            if (spot_taken[i] || trk_cnt >= MAX_SPOTS)
                continue;
            trk_ph[trk_cnt] = TAP_READY;
            tap_advance(trk_cnt, 1'b1, spot_x_buf[i], spot_y_buf[i], now);
            trk_cnt++;
        end

        for (int j = 0; j < trk_cnt; j++)
            if (!trk_hit[j])
                tap_advance(j, 1'b0, '0, '0, now);

        // Completed taps may become points; finished tracks are squeezed out.
        w = 0;
        for (int j = 0; j < trk_cnt; j++)
        begin
            if (trk_ph[j] == TAP_UP2)
            begin
                if (mark_cnt < POINT_COUNT && !near_marker(trk_x[j], trk_y[j]))
                begin
                    mark_x[mark_cnt] = trk_x[j];
                    mark_y[mark_cnt] = trk_y[j];
                    mark_cnt++;
                    push_result(1'b0, trk_x[j], trk_y[j], mark_cnt - 1, mark_cnt,
                                mark_cnt == POINT_COUNT, 1'b0);
                end
                continue;
            end
            if (trk_ph[j] == TAP_TIMEOUT)
                continue;
            if (w != j)
            begin
                trk_x[w]   = trk_x[j];
                trk_y[w]   = trk_y[j];
                trk_ph[w]  = trk_ph[j];
                trk_t[w]   = trk_t[j];
                trk_hit[w] = trk_hit[j];
            end
            w++;
        end
        for (int j = w; j < trk_cnt; j++)
        begin
            trk_ph[j]  = TAP_READY;
            trk_hit[j] = 1'b0;
        end
        trk_cnt = w;
    endtask

    task automatic predict_item(cmd_t c);
        bit did_frame;
        bit finished;
        did_frame = 1'b0;
        finished  = 1'b0;
        if (c.action == ACT_RESTART)
            clear_run();
        else if (c.action == ACT_SPOT)
        begin
            if (run_ph != RUN_END && spot_cnt < MAX_SPOTS)
            begin
                spot_x_buf[spot_cnt] = c.spot_x;
                spot_y_buf[spot_cnt] = c.spot_y;
                spot_cnt++;
            end
        end
        else if (c.action == ACT_EOF)
        begin
            if (run_ph == RUN_END)
                spot_cnt = 0;
            else
            begin
                if (spot_cnt != 0 || trk_cnt != 0)
                begin
                    run_frame(c.now_ms);
                    did_frame = 1'b1;
                end
                spot_cnt = 0;
                if (run_ph == RUN_READY)
                    run_ph = RUN_RUNNING;
                else if (did_frame && mark_cnt >= POINT_COUNT)
                begin
                    run_ph   = RUN_END;
                    finished = 1'b1;
                end
                push_result(1'b1, '0, '0, 0, mark_cnt, finished, finished);
            end
        end
    endtask

    task automatic check_result(res_t got);
        res_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result item %p", $time, got);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        if (got !== want)
        begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
            fail_count++;
        end
        if (!got.kind)
            points_seen++;
    endtask

    // Results are compared before a newly accepted item adds its expectations.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_limit   = MIN_DIST_RST;
            radius_limit = TRACK_RADIUS_RST;
            tap_limit    = TAP_TIMEOUT_RST;
            clear_run();
            pending_results.delete();
            fail_count   = 0;
            results_seen = 0;
            points_seen  = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                results_seen++;
                check_result(result);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_DIST:     near_limit   = cfg_data;
                    REG_TRACK_RADIUS: radius_limit = cfg_data;
                    REG_TAP_TIMEOUT:  tap_limit    = cfg_data[TMO_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                predict_item(cmd);
        end
    end

endmodule

>>> dv/double_tap_calibration_marker_unit_tb.sv
// Testbench top for the calibration marker: stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module double_tap_calibration_marker_unit_tb;
    import dtcm_pkg::*;

    // Action code 3 has no meaning; the block must ignore it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // No item or result for this many cycles means the block has hung. Sender
    // gaps stay short.
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 700;
    localparam int ITEM_TARGET = 280;
    localparam int SETTINGS = 4;

    logic             clk;
    logic             rst_n;
    logic             start;
    cmd_t             cmd;
    logic             busy;
    logic             result_strobe;
    res_t             result;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int               fail_count;
    int               outstanding;
    int               results_seen;
    int               points_seen;

    int               items_sent;
    int               burst_left;
    int               idle_cycles;
    logic [TIME_W-1:0] clock_ms;
    int               tmo_now;

    double_tap_calibration_marker_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .busy          (busy),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    double_tap_calibration_marker_unit_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .points_seen   (points_seen)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // The watchdog restarts its count on every accepted item or result.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sends one item. The sender always sits at a falling edge here. The
    // previous item may still be on the bus while busy is high; that is harmless
    // because nothing is taken while busy is high. Gaps come between bursts.
    task automatic send_item(logic [1:0] act, int x, int y, logic [TIME_W-1:0] now);
        if (burst_left == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        while (busy)
            @(negedge clk);
        cmd.action = act;
        cmd.spot_x = COORD_W'(x);
        cmd.spot_y = COORD_W'(y);
        cmd.now_ms = now;
        start      = 1'b1;
        @(posedge clk);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_spot(int x, int y);
        send_item(ACT_SPOT, x, y, $urandom);
    endtask

    task automatic send_frame_end(logic [TIME_W-1:0] now);
        send_item(ACT_EOF, $urandom_range(0, 4095), $urandom_range(0, 4095), now);
    endtask

    // Holds the sender off until every predicted result has been seen and the
    // block has gone idle.
    task automatic drain();
        start = 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        drain();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Moves the frame clock forward: mostly within the tap timeout, sometimes
    // just past it, and now and then by a random jump that may wrap.
    task automatic advance_clock();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            clock_ms = clock_ms + $urandom;
        else if (pick < 3)
            clock_ms = clock_ms + tmo_now + $urandom_range(1, 50);
        else
            clock_ms = clock_ms + $urandom_range(0, tmo_now);
    endtask

    function automatic int jitter(int c);
        int v;
        v = c + $urandom_range(0, 2) - 1;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return v;
    endfunction

    // One gesture: four frames, normally down-up-down-up at one place, with
    // random stray spots. Some gestures break the pattern or bring a twin tap
    // six pixels away, which completes together with the first one.
    task automatic tap_gesture();
        int  gx;
        int  gy;
        bit  broken;
        bit  twin;
        bit  present;
        gx     = ($urandom_range(0, 7) == 0) ? 4095 * $urandom_range(0, 1)
                                             : $urandom_range(0, 4095);
        gy     = ($urandom_range(0, 7) == 0) ? 4095 * $urandom_range(0, 1)
                                             : $urandom_range(0, 4095);
        broken = ($urandom_range(0, 5) == 0);
        twin   = ($urandom_range(0, 7) == 0);
        for (int f = 0; f < 4; f++)
        begin
            present = broken ? $urandom_range(0, 1) : (f % 2 == 0);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 2))
                    send_spot($urandom_range(0, 4095), $urandom_range(0, 4095));
            if (present)
            begin
                send_spot(jitter(gx), jitter(gy));
                if (twin)
                    send_spot(gx > 4000 ? gx - 6 : gx + 6, gy);
            end
            advance_clock();
            send_frame_end(clock_ms);
        end
    endtask

    task automatic random_traffic(int until_count);
        int pick;
        while (items_sent < until_count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_item(ACT_RESTART, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom);
            else if (pick < 7)
                send_item(ACT_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 4095),
                          $urandom);
            else if (pick < 10)
            begin
                // A crowded frame, filling the buffer and often more than it holds.
                repeat ($urandom_range(8, 11))
                    send_spot($urandom_range(0, 4095), $urandom_range(0, 4095));
                advance_clock();
                send_frame_end(clock_ms);
            end
            else
                tap_gesture();
        end
    endtask

    task automatic directed_items();
        send_item(ACT_RESTART, 0, 0, '0);
        send_item(ACT_UNUSED, 4095, 4095, '1);
        // An empty first frame only moves the run out of its ready phase.
        send_frame_end('0);
        // A clean double tap at the origin, with the tick wrapping midway.
        send_spot(0, 0);
        send_frame_end(32'hFFFF_FFF0);
        send_frame_end(32'hFFFF_FFF8);
        send_spot(0, 0);
        send_frame_end(32'd5);
        send_frame_end(32'd10);
        // Nine spots in one frame: the ninth must be dropped.
        for (int i = 0; i < 9; i++)
            send_spot(4095 - (i % 2) * 4095, 4095 - 500 * i);
        send_frame_end(32'd20);
    endtask

    logic [CFG_W-1:0] set_near  [SETTINGS];
    logic [CFG_W-1:0] set_rad   [SETTINGS];
    logic [TMO_W-1:0] set_tmo   [SETTINGS];

    initial
    begin
        set_near = '{MIN_DIST_RST, 25'd0, 25'h1FF_FFFF, 25'd2500};
        set_rad  = '{TRACK_RADIUS_RST, 25'h1FF_FFFF, 25'd0, 25'd25};
        set_tmo  = '{TAP_TIMEOUT_RST, 16'd0, 16'hFFFF, 16'd300};

        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_index   = REG_MIN_DIST;
        cfg_data    = '0;
        items_sent  = 0;
        burst_left  = 0;
        idle_cycles = 0;
        clock_ms    = $urandom;
        tmo_now     = TAP_TIMEOUT_RST;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The first setting is the reset one; the others are written while
        // the block is idle, each followed by a restart of the run.
        for (int s = 0; s < SETTINGS; s++)
        begin
            if (s != 0)
            begin
                write_reg(REG_MIN_DIST, set_near[s]);
                write_reg(REG_TRACK_RADIUS, set_rad[s]);
                write_reg(REG_TAP_TIMEOUT, CFG_W'(set_tmo[s]));
                tmo_now = set_tmo[s];
                send_item(ACT_RESTART, 0, 0, '0);
            end
            else
                directed_items();
            random_traffic(items_sent + (ITEM_TARGET / SETTINGS) / 2);
            // Let everything settle once in mid-phase before going on.
            if (s == 2)
                drain();
            random_traffic(items_sent + (ITEM_TARGET / SETTINGS) / 2);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items over %0d register settings, checking %0d results",
                 items_sent, SETTINGS, results_seen);
        $display("of which %0d were accepted calibration points.", points_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
